>>> rtl/core/pstg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pstg_pkg: shared types and constants of the polyline strip generator
// Default formats, register indexes, state types and unit status.
// ----------------------------------------------------------------------------
package pstg_pkg;

  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned REG_IDX_BITS   = 2;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_STRIP_WIDTH  = 2'd0,
    REG_BOTTOM_V     = 2'd1,
    REG_TEX_SCALE    = 2'd2,
    REG_LENGTH_START = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_DIV_START,
    ST_DIV,
    ST_HAND
  } core_state_e;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_SQUARE,
    DS_ROOT
  } dist_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/pstg_dist.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pstg_dist: bit-serial euclidean distance
// Squares three magnitudes one multiplier bit per cycle into a shared
// accumulator, then takes the floor square root two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pstg_dist #(
  parameter int unsigned MAG_BITS = pstg_pkg::COORD_BITS_DEF + 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [MAG_BITS-1:0]   mag_x_i,
  input  wire logic [MAG_BITS-1:0]   mag_y_i,
  input  wire logic [MAG_BITS-1:0]   mag_z_i,
  output logic      [MAG_BITS:0]     root_o,
  output pstg_pkg::unit_stat_t       stat_o
);

  localparam int unsigned M        = MAG_BITS;
  localparam int unsigned ACC_BITS = 2 * M + 2;
  localparam int unsigned SUM_BITS = M + 3;
  localparam int unsigned REM_BITS = M + 2;
  localparam int unsigned R2_BITS  = M + 4;
  localparam int unsigned CNT_BITS = $clog2(M + 2);

  pstg_pkg::dist_state_e state_q, state_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  done_q, done_d;

  logic [M-1:0]          mc_x_q, mc_y_q, mc_z_q, mc_x_d, mc_y_d, mc_z_d;
  logic [M-1:0]          mp_x_q, mp_y_q, mp_z_q, mp_x_d, mp_y_d, mp_z_d;
  logic [ACC_BITS-1:0]   acc_q, acc_d;
  logic [REM_BITS-1:0]   rem_q, rem_d;
  logic [M:0]            root_q, root_d;

  logic [M-1:0]          pp_x, pp_y, pp_z;
  logic [SUM_BITS-1:0]   sum;
  logic [R2_BITS-1:0]    rem2, trial, diff;
  logic                  ge;

  // three partial products added to the upper accumulator half
  assign pp_x = mp_x_q[0] ? mc_x_q : '0;
  assign pp_y = mp_y_q[0] ? mc_y_q : '0;
  assign pp_z = mp_z_q[0] ? mc_z_q : '0;
  assign sum  = SUM_BITS'(acc_q[ACC_BITS-1:M]) + SUM_BITS'(pp_x)
              + SUM_BITS'(pp_y) + SUM_BITS'(pp_z);

  // restoring root step on the next two radicand bits
  assign rem2  = {rem_q, acc_q[ACC_BITS-1 -: 2]};
  assign trial = R2_BITS'({root_q, 2'b01});
  assign ge    = (rem2 >= trial);
  assign diff  = rem2 - trial;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    mc_x_d  = mc_x_q;
    mc_y_d  = mc_y_q;
    mc_z_d  = mc_z_q;
    mp_x_d  = mp_x_q;
    mp_y_d  = mp_y_q;
    mp_z_d  = mp_z_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    root_d  = root_q;
    unique case (state_q)
      pstg_pkg::DS_IDLE: begin
        if (start_i) begin
          mc_x_d  = mag_x_i;
          mc_y_d  = mag_y_i;
          mc_z_d  = mag_z_i;
          mp_x_d  = mag_x_i;
          mp_y_d  = mag_y_i;
          mp_z_d  = mag_z_i;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = pstg_pkg::DS_SQUARE;
        end
      end
      pstg_pkg::DS_SQUARE: begin
        acc_d  = {sum, acc_q[M-1:1]};
        mp_x_d = mp_x_q >> 1;
        mp_y_d = mp_y_q >> 1;
        mp_z_d = mp_z_q >> 1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(M - 1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          root_d  = '0;
          state_d = pstg_pkg::DS_ROOT;
        end
      end
      pstg_pkg::DS_ROOT: begin
        acc_d  = {acc_q[ACC_BITS-3:0], 2'b00};
        rem_d  = ge ? diff[REM_BITS-1:0] : rem2[REM_BITS-1:0];
        root_d = {root_q[M-1:0], ge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(M)) begin
          cnt_d   = '0;
          done_d  = 1'b1;
          state_d = pstg_pkg::DS_IDLE;
        end
      end
      default: begin
        state_d = pstg_pkg::DS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pstg_pkg::DS_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mc_x_q <= mc_x_d;
    mc_y_q <= mc_y_d;
    mc_z_q <= mc_z_d;
    mp_x_q <= mp_x_d;
    mp_y_q <= mp_y_d;
    mp_z_q <= mp_z_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o      = root_q;
  assign stat_o.busy = (state_q != pstg_pkg::DS_IDLE);
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

>>> rtl/core/pstg_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pstg_div: serial fixed-point divider
// Restoring division of |arc| * 2^FRAC_BITS by the scale, one quotient bit per
// cycle, with sign restore and saturation to the signed coordinate range.
// ----------------------------------------------------------------------------
module pstg_div #(
  parameter int unsigned COORD_BITS = pstg_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = pstg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [COORD_BITS-1:0]   arc_i,
  input  wire logic [COORD_BITS-2:0]   scale_i,
  output logic      [COORD_BITS-1:0]   quot_o,
  output pstg_pkg::unit_stat_t         stat_o
);

  localparam int unsigned W        = COORD_BITS;
  localparam int unsigned F        = FRAC_BITS;
  localparam int unsigned DVD_BITS = W + F;
  localparam int unsigned CNT_BITS = $clog2(W + F);
  localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;

  logic                neg_q, neg_d;
  logic                ovf_q, ovf_d;
  logic [DVD_BITS-1:0] dvd_q, dvd_d;
  logic [W-2:0]        rem_q, rem_d;
  logic [W-1:0]        q_q, q_d;

  logic [W-1:0]        rem2, diff, arc_mag;
  logic                ge;

  assign rem2    = {rem_q, dvd_q[DVD_BITS-1]};
  assign ge      = (rem2 >= {1'b0, scale_i});
  assign diff    = rem2 - {1'b0, scale_i};
  assign arc_mag = arc_i[W-1] ? (W'(0) - arc_i) : arc_i;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    ovf_d  = ovf_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    q_d    = q_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        cnt_d  = '0;
        neg_d  = arc_i[W-1];
        ovf_d  = 1'b0;
        dvd_d  = {arc_mag, {F{1'b0}}};
        rem_d  = '0;
        q_d    = '0;
      end
    end else begin
      dvd_d = {dvd_q[DVD_BITS-2:0], 1'b0};
      rem_d = ge ? diff[W-2:0] : rem2[W-2:0];
      // a quotient bit pushed past the top means the result overflows
      ovf_d = ovf_q | q_q[W-1];
      q_d   = {q_q[W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_BITS'(DVD_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    ovf_q <= ovf_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    q_q   <= q_d;
  end

  always_comb begin
    if (ovf_q) begin
      quot_o = neg_q ? MIN_VAL : MAX_VAL;
    end else if (neg_q) begin
      quot_o = (q_q > MIN_VAL) ? MIN_VAL : (W'(0) - q_q);
    end else begin
      quot_o = q_q[W-1] ? MAX_VAL : q_q;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

>>> rtl/core/polyline_strip_texcoord_gen.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_strip_texcoord_gen: strip vertices with arc-length texture coords
// Turns each polyline vertex into a lower and an upper strip vertex.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one polyline vertex per transfer (pos_x/y/z, first_vertex);
//   in_stall_o is high while a vertex is being worked on.
//   out channel: two transfers per vertex, the lower strip vertex first and
//   the upper one (pair_last_o high) second.
//   a vertex that continues a polyline goes through the distance unit, which
//   squares one bit per cycle and extracts the root two bits per cycle, and
//   then through the divider, which makes one quotient bit per cycle (Q16.16
//   coordinates by default). a first vertex skips the distance unit. the
//   next vertex is taken in the cycle after the results are handed to the
//   output register, so a new vertex enters only once the last one is done.
//   a stalled receiver holds the output register; the next vertex is still
//   worked on and waits in the core until the register frees up.
//   reset restores the register defaults (width 1.0, bottom v 1.0,
//   scale 1.0, start length 0) and clears previous vertex and arc length.
//   registers must be written only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module polyline_strip_texcoord_gen #(
  parameter int unsigned COORD_BITS = pstg_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = pstg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration
  input  wire logic                                  cfg_we_i,
  input  wire logic [pstg_pkg::REG_IDX_BITS-1:0]     cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]                 cfg_data_i,
  // vertex input
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [COORD_BITS-1:0]          pos_x_i,
  input  wire logic signed [COORD_BITS-1:0]          pos_y_i,
  input  wire logic signed [COORD_BITS-1:0]          pos_z_i,
  input  wire logic                                  first_vertex_i,
  // strip vertex output
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [COORD_BITS-1:0]               out_x_o,
  output logic signed [COORD_BITS-1:0]               out_y_o,
  output logic signed [COORD_BITS-1:0]               out_z_o,
  output logic signed [COORD_BITS-1:0]               tex_u_o,
  output logic signed [COORD_BITS-1:0]               tex_v_o,
  output logic                                       pair_last_o
);

  localparam int unsigned W        = COORD_BITS;
  localparam int unsigned F        = FRAC_BITS;
  localparam int unsigned SW       = W - 1;
  localparam int unsigned SUM_BITS = W + 3;
  localparam logic [W-1:0]  MAX_VAL   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MIN_VAL   = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]  ONE_VAL   = W'(1) << F;
  localparam logic [SW-1:0] ONE_SCALE = SW'(1) << F;

  function automatic logic [W:0] abs_diff(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] d;
    d = {a[W-1], a} - {b[W-1], b};
    return d[W] ? ((W+1)'(0) - d) : d;
  endfunction

  // configuration registers
  logic [W-1:0]  strip_width_q, bottom_v_q, length_start_q;
  logic [SW-1:0] tex_scale_q;

  // core state
  pstg_pkg::core_state_e state_q, state_d;
  logic [W-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic [W-1:0] arc_q, arc_d;

  // output register
  logic         out_valid_q, out_valid_d;
  logic         out_phase_q, out_phase_d;
  logic [W-1:0] ox_q, oy_q, oz_q, ou_q, oyup_q;

  logic in_xfer, out_xfer, hand_off;
  logic dist_start, div_start;

  pstg_pkg::unit_stat_t dist_stat, div_stat;
  logic [W+1:0]         dist_root;
  logic [W-1:0]         div_quot;

  logic [SUM_BITS-1:0]  arc_sum;
  logic                 arc_over;
  logic [W-1:0]         arc_sat;
  logic [W:0]           yup_sum;
  logic [W-1:0]         yup_sat;

  assign in_stall_o = (state_q != pstg_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign hand_off   = (state_q == pstg_pkg::ST_HAND) && !out_valid_q;
  assign dist_start = in_xfer && !first_vertex_i;
  assign div_start  = (state_q == pstg_pkg::ST_DIV_START);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_width_q  <= ONE_VAL;
      bottom_v_q     <= ONE_VAL;
      tex_scale_q    <= ONE_SCALE;
      length_start_q <= '0;
    end else if (cfg_we_i) begin
      unique case (pstg_pkg::reg_idx_e'(cfg_idx_i))
        pstg_pkg::REG_STRIP_WIDTH:  strip_width_q  <= cfg_data_i;
        pstg_pkg::REG_BOTTOM_V:     bottom_v_q     <= cfg_data_i;
        pstg_pkg::REG_TEX_SCALE:    tex_scale_q    <= cfg_data_i[SW-1:0];
        pstg_pkg::REG_LENGTH_START: length_start_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pstg_dist #(
    .MAG_BITS (W + 1)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_start),
    .mag_x_i (abs_diff(pos_x_i, prev_x_q)),
    .mag_y_i (abs_diff(pos_y_i, prev_y_q)),
    .mag_z_i (abs_diff(pos_z_i, prev_z_q)),
    .root_o  (dist_root),
    .stat_o  (dist_stat)
  );

  pstg_div #(
    .COORD_BITS (W),
    .FRAC_BITS  (F)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .arc_i   (arc_q),
    .scale_i (tex_scale_q),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  // arc length plus distance, saturated at the top only (distance is positive)
  assign arc_sum  = {{3{arc_q[W-1]}}, arc_q} + SUM_BITS'(dist_root);
  assign arc_over = !arc_sum[SUM_BITS-1] && (arc_sum[SUM_BITS-2:W-1] != '0);
  assign arc_sat  = arc_over ? MAX_VAL : arc_sum[W-1:0];

  assign yup_sum = {prev_y_q[W-1], prev_y_q} + {strip_width_q[W-1], strip_width_q};
  assign yup_sat = (yup_sum[W] != yup_sum[W-1]) ? (yup_sum[W] ? MIN_VAL : MAX_VAL)
                                                 : yup_sum[W-1:0];

  always_comb begin
    state_d = state_q;
    arc_d   = arc_q;
    unique case (state_q)
      pstg_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (first_vertex_i) begin
            arc_d   = length_start_q;
            state_d = pstg_pkg::ST_DIV_START;
          end else begin
            state_d = pstg_pkg::ST_DIST;
          end
        end
      end
      pstg_pkg::ST_DIST: begin
        if (dist_stat.done) begin
          arc_d   = arc_sat;
          state_d = pstg_pkg::ST_DIV_START;
        end
      end
      pstg_pkg::ST_DIV_START: begin
        state_d = pstg_pkg::ST_DIV;
      end
      pstg_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = pstg_pkg::ST_HAND;
        end
      end
      pstg_pkg::ST_HAND: begin
        if (!out_valid_q) begin
          state_d = pstg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pstg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pstg_pkg::ST_IDLE;
      arc_q    <= '0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      prev_z_q <= '0;
    end else begin
      state_q <= state_d;
      arc_q   <= arc_d;
      if (in_xfer) begin
        prev_x_q <= pos_x_i;
        prev_y_q <= pos_y_i;
        prev_z_q <= pos_z_i;
      end
    end
  end

  // output register: lower vertex, then upper vertex
  always_comb begin
    out_valid_d = out_valid_q;
    out_phase_d = out_phase_q;
    if (hand_off) begin
      out_valid_d = 1'b1;
      out_phase_d = 1'b0;
    end else if (out_xfer) begin
      if (out_phase_q) begin
        out_valid_d = 1'b0;
        out_phase_d = 1'b0;
      end else begin
        out_phase_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_phase_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      out_phase_q <= out_phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hand_off) begin
      ox_q   <= prev_x_q;
      oy_q   <= prev_y_q;
      oz_q   <= prev_z_q;
      ou_q   <= div_quot;
      oyup_q <= yup_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = out_phase_q ? oyup_q : oy_q;
  assign out_z_o     = oz_q;
  assign tex_u_o     = ou_q;
  assign tex_v_o     = out_phase_q ? '0 : bottom_v_q;
  assign pair_last_o = out_phase_q;

  // upper vertex only shows while a result is held
  a_phase_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_phase_q |-> out_valid_q)
    else $error("upper strip vertex without valid output");

  // a handoff always starts with the lower vertex
  a_hand_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hand_off |=> (out_valid_o && !pair_last_o))
    else $error("handoff did not present the lower vertex");

  a_dist_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_stat.done |-> (state_q == pstg_pkg::ST_DIST))
    else $error("distance finished outside the distance state");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == pstg_pkg::ST_DIV))
    else $error("division finished outside the divide state");

  a_units_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dist_stat.busy && div_stat.busy))
    else $error("distance unit and divider busy together");

endmodule
`default_nettype wire
